// ===== rtl/core/ppsch_pkg.sv =====
package ppsch_pkg;

    localparam int ARR_W   = 16;
    localparam int BURST_W = 8;
    localparam int PRIO_W  = 8;
    localparam int TIME_W  = 16;
    localparam int SUM_W   = 24;
    localparam int SLOT_W  = 4;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 104;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;
    localparam logic [SUM_W-1:0]  SUM_MAX  = '1;

    // one table row: arrival, original burst, remaining work, priority
    typedef struct packed {
        logic [ARR_W-1:0]   arrival;
        logic [BURST_W-1:0] burst;
        logic [BURST_W-1:0] remaining;
        logic [PRIO_W-1:0]  prio;
    } entry_t;

    typedef struct packed {
        logic capture;
        logic load;
        logic scan_en;
        logic update;
        logic calc;
        logic accum;
        logic emit;
    } ctl_cmd_t;

    typedef struct packed {
        logic in_tick;
        logic scan_done;
        logic out_free;
    } ctl_status_t;

endpackage

// ===== rtl/core/ppsch_ctrl.sv =====
module ppsch_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  ppsch_pkg::ctl_status_t status,
    output ppsch_pkg::ctl_cmd_t    cmd
);
    import ppsch_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LOAD   = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_UPDATE = 3'd3;
    localparam logic [2:0] ST_CALC   = 3'd4;
    localparam logic [2:0] ST_ACCUM  = 3'd5;
    localparam logic [2:0] ST_EMIT   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                // take no beat while reset is asserted
                s_tready = aresetn;
                if (s_tvalid && aresetn) begin
                    cmd.capture = 1'b1;
                    state_next  = status.in_tick ? ST_SCAN : ST_LOAD;
                end
            end
            ST_LOAD: begin
                cmd.load   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_SCAN: begin
                cmd.scan_en = 1'b1;
                if (status.scan_done) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = ST_CALC;
            end
            ST_CALC: begin
                cmd.calc   = 1'b1;
                state_next = ST_ACCUM;
            end
            ST_ACCUM: begin
                cmd.accum  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/ppsch_dp.sv =====
module ppsch_dp #(
    parameter int MAX_PROCS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  ppsch_pkg::ctl_cmd_t                 cmd,
    output ppsch_pkg::ctl_status_t              status,
    input  logic                                s_tuser,
    input  logic [ppsch_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ppsch_pkg::M_TDATA_W-1:0]     m_tdata
);
    import ppsch_pkg::*;

    localparam int IDX_W = $clog2(MAX_PROCS);
    localparam int CNT_W = $clog2(MAX_PROCS + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_PROCS);

    // task table
    entry_t mem [MAX_PROCS];
    entry_t rd_data_reg;

    // captured load fields
    logic [ARR_W-1:0]   in_arr_reg;
    logic [BURST_W-1:0] in_burst_reg;
    logic [PRIO_W-1:0]  in_prio_reg;

    // counters and time
    logic [CNT_W-1:0]  task_count_reg;
    logic [CNT_W-1:0]  done_count_reg;
    logic [TIME_W-1:0] clock_time_reg;
    logic [SUM_W-1:0]  sum_tat_reg;
    logic [SUM_W-1:0]  sum_wt_reg;

    // scan
    logic [CNT_W-1:0] scan_idx_reg;
    logic             rd_pend_reg;
    logic [IDX_W-1:0] rd_slot_reg;
    logic             found_reg;
    entry_t           best_reg;
    logic [IDX_W-1:0] best_slot_reg;

    // per-item results
    logic              acc_reg;
    logic              ran_reg;
    logic              fin_reg;
    logic [TIME_W-1:0] tat_reg;
    logic [TIME_W-1:0] wt_reg;

    // output register
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic              table_full;
    logic              scan_active;
    logic              eligible;
    logic              better;
    logic [TIME_W-1:0] time_inc;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    entry_t            mem_wdata;
    logic [SUM_W:0]    sum_tat_next;
    logic [SUM_W:0]    sum_wt_next;
    logic              all_done;

    assign table_full  = (task_count_reg == CNT_FULL);
    assign scan_active = (scan_idx_reg < task_count_reg);
    assign time_inc    = (clock_time_reg == TIME_MAX) ? clock_time_reg
                                                      : clock_time_reg + 1'b1;

    assign eligible = (rd_data_reg.arrival <= clock_time_reg) && (rd_data_reg.remaining != '0);
    assign better   = !found_reg
                   || (rd_data_reg.prio < best_reg.prio)
                   || ((rd_data_reg.prio == best_reg.prio)
                       && (rd_data_reg.arrival < best_reg.arrival));

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = task_count_reg[IDX_W-1:0];
        mem_wdata = '{arrival: in_arr_reg, burst: in_burst_reg,
                      remaining: in_burst_reg, prio: in_prio_reg};
        if (cmd.load && !table_full) begin
            mem_we = 1'b1;
        end else if (cmd.update && found_reg) begin
            mem_we              = 1'b1;
            mem_waddr           = best_slot_reg;
            mem_wdata           = best_reg;
            mem_wdata.remaining = best_reg.remaining - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.scan_en && scan_active) begin
            rd_data_reg <= mem[scan_idx_reg[IDX_W-1:0]];
        end
    end

    assign sum_tat_next = {1'b0, sum_tat_reg} + (SUM_W + 1)'(tat_reg);
    assign sum_wt_next  = {1'b0, sum_wt_reg} + (SUM_W + 1)'(wt_reg);
    assign all_done     = (done_count_reg == task_count_reg);

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            task_count_reg <= '0;
            done_count_reg <= '0;
            clock_time_reg <= '0;
            sum_tat_reg    <= '0;
            sum_wt_reg     <= '0;
            scan_idx_reg   <= '0;
            rd_pend_reg    <= 1'b0;
            found_reg      <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cmd.capture) begin
                scan_idx_reg <= '0;
                rd_pend_reg  <= 1'b0;
                found_reg    <= 1'b0;
            end
            if (cmd.scan_en) begin
                rd_pend_reg <= scan_active;
                if (scan_active) begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                end
                if (rd_pend_reg && eligible && better) begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.load && !table_full) begin
                task_count_reg <= task_count_reg + 1'b1;
            end
            if (cmd.update) begin
                clock_time_reg <= time_inc;
                if (found_reg && best_reg.remaining == BURST_W'(1)) begin
                    done_count_reg <= done_count_reg + 1'b1;
                end
            end
            if (cmd.calc && fin_reg) begin
                sum_tat_reg <= sum_tat_next[SUM_W] ? SUM_MAX : sum_tat_next[SUM_W-1:0];
            end
            if (cmd.accum && fin_reg) begin
                sum_wt_reg <= sum_wt_next[SUM_W] ? SUM_MAX : sum_wt_next[SUM_W-1:0];
            end
            if (cmd.emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_arr_reg   <= s_tdata[ARR_W-1:0];
            in_burst_reg <= s_tdata[ARR_W+BURST_W-1:ARR_W];
            in_prio_reg  <= s_tdata[ARR_W+BURST_W+PRIO_W-1:ARR_W+BURST_W];
        end
        if (cmd.scan_en && scan_active) begin
            rd_slot_reg <= scan_idx_reg[IDX_W-1:0];
        end
        if (cmd.scan_en && rd_pend_reg && eligible && better) begin
            best_reg      <= rd_data_reg;
            best_slot_reg <= rd_slot_reg;
        end
        if (cmd.load) begin
            acc_reg <= !table_full;
            ran_reg <= 1'b0;
            fin_reg <= 1'b0;
            tat_reg <= '0;
            wt_reg  <= '0;
        end
        if (cmd.update) begin
            acc_reg <= 1'b0;
            ran_reg <= found_reg;
            fin_reg <= found_reg && (best_reg.remaining == BURST_W'(1));
            if (found_reg && best_reg.remaining == BURST_W'(1)) begin
                tat_reg <= time_inc - best_reg.arrival;
            end else begin
                tat_reg <= '0;
            end
        end
        if (cmd.calc) begin
            wt_reg <= (fin_reg && tat_reg >= TIME_W'(best_reg.burst))
                    ? tat_reg - TIME_W'(best_reg.burst) : '0;
        end
        if (cmd.emit) begin
            m_tdata_reg <= {all_done, sum_wt_reg, sum_tat_reg, wt_reg, tat_reg, fin_reg,
                            clock_time_reg,
                            ran_reg ? SLOT_W'(best_slot_reg) : SLOT_W'(0),
                            ran_reg, acc_reg};
        end
    end

    assign status.in_tick   = s_tuser;
    assign status.scan_done = !scan_active && !rd_pend_reg;
    assign status.out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== rtl/core/preemptive_priority_scheduler.sv =====
// Channel  Dir  Signals                      Contents
// s_       in   s_tvalid s_tready s_tuser    tuser: cmd (0 load, 1 tick)
//                s_tdata[31:0]               arrival, burst, prio
// m_       out  m_tvalid m_tready            one result beat per input beat
//                m_tdata[103:0]              status, time and totals
//
// A load beat runs through the LOAD and EMIT states and a tick beat through
// SCAN, UPDATE, CALC, ACCUM and EMIT before its result is valid on m_; the
// next beat is taken only once the controller is back in IDLE. The task
// table is read one slot per cycle, so the scan over the loaded slots makes
// a tick take longer than a load.
// aresetn (synchronous) clears the counters, time and totals; the table
// needs no clearing since only loaded slots are read.
// A new beat is taken while the previous result still waits on m_; the
// block then holds its finished result until the output register frees.
module preemptive_priority_scheduler #(
    parameter int MAX_PROCS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // cmd
    input  logic                            s_tuser,
    // arrival[15:0], burst[23:16], prio[31:24]
    input  logic [ppsch_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // accepted[0], ran[1], run_slot[5:2], time_now[21:6], finished[22],
    // turnaround[38:23], waiting[54:39], total_turnaround[78:55],
    // total_waiting[102:79], all_done[103]
    output logic [ppsch_pkg::M_TDATA_W-1:0] m_tdata
);
    import ppsch_pkg::*;

    ctl_cmd_t    cmd;
    ctl_status_t status;

    // sequence: accept, then load, or scan, update, calc and accum; then emit
    ppsch_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // table memory, selection, time and totals, output register
    ppsch_dp #(
        .MAX_PROCS (MAX_PROCS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== verif/testbench.sv =====
module testbench;
    import ppsch_pkg::*;

    localparam int SLOTS          = 16;
    localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 3000;  // cycles with no beat on either side
    localparam int SETTLE_CYCLES  = 64;    // room for the slowest ticks to finish
    localparam int REPORT_CAP     = 30;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_TICK = 1'b1
    } sched_cmd_e;

    // m_tdata layout, highest field first
    typedef struct packed {
        logic              all_done;
        logic [SUM_W-1:0]  total_waiting;
        logic [SUM_W-1:0]  total_turnaround;
        logic [TIME_W-1:0] waiting;
        logic [TIME_W-1:0] turnaround;
        logic              finished;
        logic [TIME_W-1:0] time_now;
        logic [SLOT_W-1:0] run_slot;
        logic              ran;
        logic              accepted;
    } sched_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic                 s_tuser;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // shadow copy of the scheduler state
    logic [ARR_W-1:0]   slot_arrival [SLOTS];
    logic [BURST_W-1:0] slot_burst   [SLOTS];
    logic [BURST_W-1:0] slot_left    [SLOTS];
    logic [PRIO_W-1:0]  slot_prio    [SLOTS];
    int                 loaded_cnt  = 0;
    int                 retired_cnt = 0;
    logic [TIME_W-1:0]  sched_clock = '0;
    logic [SUM_W-1:0]   sum_tat     = '0;
    logic [SUM_W-1:0]   sum_wait    = '0;

    sched_result_t pending_results [$];

    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int hold_req     = 0;
    int hold_ack     = 0;
    int hold_left    = 0;
    int quiet_cycles = 0;
    int mismatch_cnt = 0;
    int results_seen = 0;

    // coverage tallies for the closing summary
    int loads_stored    = 0;
    int loads_refused   = 0;
    int ticks_total     = 0;
    int idle_ticks      = 0;
    int ticks_saturated = 0;
    int clamped_waits   = 0;

    preemptive_priority_scheduler #(
        .MAX_PROCS(SLOTS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic logic [SUM_W-1:0] add_clamped(logic [SUM_W-1:0] acc,
                                                     logic [TIME_W-1:0] inc);
        logic [SUM_W:0] total;
        total = acc + inc;
        return total[SUM_W] ? SUM_MAX : total[SUM_W-1:0];
    endfunction

    // Advance the shadow scheduler by one beat and return the result it must produce.
    function automatic sched_result_t schedule_beat(sched_cmd_e cmd,
                                                    logic [ARR_W-1:0] arr,
                                                    logic [BURST_W-1:0] bst,
                                                    logic [PRIO_W-1:0] pri);
        sched_result_t r;
        int            pick;
        bit            found;
        r     = '0;
        pick  = 0;
        found = 1'b0;
        if (cmd == CMD_LOAD) begin
            if (loaded_cnt < SLOTS) begin
                slot_arrival[loaded_cnt] = arr;
                slot_burst[loaded_cnt]   = bst;
                slot_left[loaded_cnt]    = bst;
                slot_prio[loaded_cnt]    = pri;
                loaded_cnt++;
                loads_stored++;
                r.accepted = 1'b1;
            end else begin
                loads_refused++;
            end
        end else begin
            ticks_total++;
            // lowest priority number wins, then earliest arrival, then lowest slot
            for (int i = 0; i < loaded_cnt; i++) begin
                if (slot_arrival[i] <= sched_clock && slot_left[i] != 0 &&
                    (!found || slot_prio[i] < slot_prio[pick] ||
                     (slot_prio[i] == slot_prio[pick] &&
                      slot_arrival[i] < slot_arrival[pick]))) begin
                    pick  = i;
                    found = 1'b1;
                end
            end
            if (sched_clock == TIME_MAX) begin
                ticks_saturated++;
            end else begin
                sched_clock++;
            end
            if (!found) begin
                idle_ticks++;
            end else begin
                r.ran      = 1'b1;
                r.run_slot = pick[SLOT_W-1:0];
                slot_left[pick]--;
                if (slot_left[pick] == 0) begin
                    r.finished   = 1'b1;
                    retired_cnt++;
                    r.turnaround = sched_clock - slot_arrival[pick];
                    // clamp to zero once frozen time makes waiting negative
                    if (r.turnaround >= slot_burst[pick]) begin
                        r.waiting = r.turnaround - slot_burst[pick];
                    end else begin
                        clamped_waits++;
                    end
                    sum_tat  = add_clamped(sum_tat, r.turnaround);
                    sum_wait = add_clamped(sum_wait, r.waiting);
                end
            end
        end
        r.time_now         = sched_clock;
        r.total_turnaround = sum_tat;
        r.total_waiting    = sum_wait;
        r.all_done         = (retired_cnt == loaded_cnt);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [SUM_W-1:0] got,
                                   logic [SUM_W-1:0] want);
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_CAP) begin
            $display("result %0d: %s got 0x%0h want 0x%0h", results_seen, what, got, want);
        end
    endtask

    task automatic check_field(string name, logic [SUM_W-1:0] got, logic [SUM_W-1:0] want);
        if (got !== want) begin
            report_mismatch(name, got, want);
        end
    endtask

    // Offer one beat after a random idle spell; predict once it is taken.
    // Valid stays high on return so back-to-back beats need no second assignment.
    task automatic send_beat(sched_cmd_e cmd, logic [ARR_W-1:0] arr,
                             logic [BURST_W-1:0] bst, logic [PRIO_W-1:0] pri);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {pri, bst, arr};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        pending_results.push_back(schedule_beat(cmd, arr, bst, pri));
    endtask

    // tick beats carry junk in the load fields; the block must ignore it
    task automatic send_tick();
        send_beat(CMD_TICK, ARR_W'($urandom), BURST_W'($urandom_range(255, 1)),
                  PRIO_W'($urandom));
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Small hand-built table: preemption, both tie breaks, idle ticks, empty table.
    task automatic test_directed_schedule();
        send_tick();                                    // empty table: idle, all done
        send_beat(CMD_LOAD, 16'd0, 8'd3, 8'd255);       // slot 0, runs first
        send_beat(CMD_LOAD, 16'd3, 8'd2, 8'd9);         // slot 1
        send_beat(CMD_LOAD, 16'd2, 8'd2, 8'd9);         // slot 2, earlier arrival than slot 1
        send_beat(CMD_LOAD, 16'd3, 8'd1, 8'd9);         // slot 3, loses to slot 1 on slot order
        send_beat(CMD_LOAD, 16'd4, 8'd1, 8'd0);         // slot 4, preempts everyone
        while (retired_cnt != loaded_cnt) begin
            send_tick();
        end
        send_tick();                                    // idle tick with everything retired
        send_beat(CMD_LOAD, TIME_MAX, 8'd255, 8'd255);  // arrives at the last time value
        send_tick();                                    // loaded but not yet arrived
        wait_results_drained();
    endtask

    // Random loads with near-future arrivals mixed into a stream of ticks.
    task automatic test_random_mix(int items, int task_cap);
        logic [ARR_W-1:0]   arr;
        logic [BURST_W-1:0] bst;
        logic [PRIO_W-1:0]  pri;
        repeat (items) begin
            if (loaded_cnt < task_cap && $urandom_range(29) == 0) begin
                arr = sched_clock + ARR_W'($urandom_range(400));
                if ($urandom_range(1)) begin
                    arr[2:0] = 3'b000;                  // coarse arrivals force ties
                end
                bst = BURST_W'(($urandom_range(3) == 0) ? $urandom_range(16, 1)
                                                        : $urandom_range(255, 1));
                pri = PRIO_W'(($urandom_range(3) != 0) ? $urandom_range(7)
                                                       : $urandom_range(255));
                send_beat(CMD_LOAD, arr, bst, pri);
            end else begin
                send_tick();
            end
        end
        wait_results_drained();
    endtask

    // Hold m_tready low for a long stretch while ticks keep coming, so s_tready drops.
    task automatic test_output_backpressure();
        hold_req <= hold_req + 1;
        repeat (40) begin
            send_tick();
        end
        wait_results_drained();
    endtask

    // Fill the table with tasks that have already arrived, overflow it, then keep ticking.
    task automatic test_full_table();
        while (loaded_cnt < SLOTS) begin
            send_beat(CMD_LOAD, sched_clock - ARR_W'($urandom_range(30)),
                      BURST_W'($urandom_range(8, 1)), PRIO_W'($urandom_range(3)));
            repeat ($urandom_range(4)) begin
                send_tick();
            end
        end
        repeat (3) begin
            send_beat(CMD_LOAD, ARR_W'($urandom), BURST_W'($urandom_range(255, 1)),
                      PRIO_W'($urandom));
        end
        repeat (80) begin
            send_tick();
        end
        wait_results_drained();
    endtask

    // Receiver: random ready, or a counted hold-off when a test asks for one.
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_ack) begin
            m_tready  <= 1'b0;
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Compare every result beat against the oldest prediction.
    always @(posedge aclk) begin : result_check
        sched_result_t got;
        sched_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            got = sched_result_t'(m_tdata);
            if (pending_results.size() == 0) begin
                report_mismatch("result with no beat pending", m_tdata[SUM_W-1:0], '0);
            end else begin
                want = pending_results.pop_front();
                check_field("accepted", SUM_W'(got.accepted), SUM_W'(want.accepted));
                check_field("ran", SUM_W'(got.ran), SUM_W'(want.ran));
                check_field("run_slot", SUM_W'(got.run_slot), SUM_W'(want.run_slot));
                check_field("time_now", SUM_W'(got.time_now), SUM_W'(want.time_now));
                check_field("finished", SUM_W'(got.finished), SUM_W'(want.finished));
                check_field("turnaround", SUM_W'(got.turnaround), SUM_W'(want.turnaround));
                check_field("waiting", SUM_W'(got.waiting), SUM_W'(want.waiting));
                check_field("total_turnaround", got.total_turnaround, want.total_turnaround);
                check_field("total_waiting", got.total_waiting, want.total_waiting);
                check_field("all_done", SUM_W'(got.all_done), SUM_W'(want.all_done));
            end
        end
    end

    // Abort if nothing moves on either side for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", quiet_cycles);
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= CMD_LOAD;
        s_tdata  <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_idle_pct = 15;
        rx_idle_pct = 72;
        test_directed_schedule();
        test_random_mix(850, 8);

        tx_idle_pct = 72;
        rx_idle_pct = 15;
        test_random_mix(850, 10);
        test_output_backpressure();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_full_table();

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0) begin
            report_mismatch("results never delivered", SUM_W'(pending_results.size()), '0);
        end

        $display("Ran %0d loads (%0d refused on a full table) and %0d ticks, %0d of them idle",
                 loads_stored + loads_refused, loads_refused, ticks_total, idle_ticks);
        $display("%0d ticks with time pinned at max, %0d tasks retired, %0d zero-clamped waits",
                 ticks_saturated, retired_cnt, clamped_waits);
        if (mismatch_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/core/ppsch_pkg.sv
rtl/core/ppsch_ctrl.sv
rtl/core/ppsch_dp.sv
rtl/core/preemptive_priority_scheduler.sv
verif/testbench.sv
